// ===== design/key_value_argument_parser_unit_macros.svh =====
// Assertion macros for the key/value argument parser checker.
// Each macro expands to one labeled concurrent assertion, clocked and
// reset by the signals passed in.
`ifndef KEY_VALUE_ARGUMENT_PARSER_UNIT_MACROS_SVH
`define KEY_VALUE_ARGUMENT_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define KVAP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define KVAP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/kvap_pkg.sv =====
// Shared types, constants and helper functions of the key/value argument parser.
// Used by the channel interfaces, the top level and the checker.
`default_nettype none

package kvap_pkg;

    localparam int KEY_COUNT = 16;
    localparam int KEY_LEN   = 16;
    localparam int TEXT_LEN  = 4096;

    localparam int BYTE_W    = 8;
    localparam int OP_W      = 2;
    localparam int KEY_W     = $clog2(KEY_COUNT);
    localparam int POS_W     = $clog2(KEY_LEN);
    localparam int SEG_W     = $clog2(KEY_LEN + 2);
    localparam int OFFSET_W  = 12;
    localparam int LENGTH_W  = 13;
    localparam int TEXT_W    = $clog2(TEXT_LEN) + 1;
    localparam int NUMKEYS_W = 5;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    localparam logic [BYTE_W-1:0] CHAR_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_AMP    = 8'h26;
    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_DELTA   = 8'h20;

    typedef enum logic [OP_W-1:0] {
        OP_KEY_WRITE = 2'd0,
        OP_TEXT_BYTE = 2'd1,
        OP_END_TEXT  = 2'd2
    } op_t;

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } state_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] folded;
        folded = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            folded = c + CASE_DELTA;
        end
        return folded;
    endfunction

endpackage

`default_nettype wire

// ===== design/kvap_if.sv =====
// Valid/ready channel interfaces of the key/value argument parser.
// Field widths come from kvap_pkg.
`default_nettype none

interface kvap_item_if;
    logic                           valid;
    logic                           ready;
    logic [kvap_pkg::OP_W-1:0]      operation;
    logic [kvap_pkg::KEY_W-1:0]     key_index;
    logic [kvap_pkg::POS_W-1:0]     char_position;
    logic [kvap_pkg::BYTE_W-1:0]    byte_value;

    modport source (output valid, operation, key_index, char_position, byte_value,
                    input ready);
    modport sink (input valid, operation, key_index, char_position, byte_value,
                  output ready);
endinterface

interface kvap_result_if;
    logic                           valid;
    logic                           ready;
    logic [kvap_pkg::KEY_W-1:0]     result_key;
    logic                           key_found;
    logic [kvap_pkg::OFFSET_W-1:0]  value_offset;
    logic [kvap_pkg::LENGTH_W-1:0]  value_length;
    logic                           last_result;

    modport source (output valid, result_key, key_found, value_offset, value_length,
                    last_result, input ready);
    modport sink (input valid, result_key, key_found, value_offset, value_length,
                  last_result, output ready);
endinterface

`default_nettype wire

// ===== design/key_value_argument_parser_unit.sv =====
// Key/value argument parser: matches '&'-separated key=value text against a key table.
// Depends on kvap_pkg and the channel interfaces in kvap_if.sv.
//
// Usage:
//   items carries one transaction per item: a key table character write, a text
//   byte or an end of text. Key writes and text bytes are taken one per cycle,
//   back to back, while items.ready is high. A text byte reads one row of the
//   key table memory (one character position across all keys) and is compared
//   against every key in the following cycle; the memory's registered read sets
//   the two-stage flow. An end of text yields N = min(num_keys, 16) results on
//   results, one per cycle while the receiver takes them, with items.ready low.
//   Once the end is accepted, the state register enters the emit state, which
//   loads the first result. results is driven from registers. When the receiver
//   stalls, the pending result holds and the sweep waits; items.ready returns high
//   once the final result of the run has been loaded, even if it has not yet been
//   taken. num_keys is written through cfg_write_en and cfg_write_data; the user
//   must do so only while idle; the block does not enforce it. Reset clears the
//   run state and num_keys; the key table holds no defined contents until written.
`default_nettype none

module key_value_argument_parser_unit (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             cfg_write_en,
    input wire [kvap_pkg::NUMKEYS_W-1:0]   cfg_write_data,
    kvap_item_if.sink                      items,
    kvap_result_if.source                  results
);

    localparam int KC = kvap_pkg::KEY_COUNT;
    localparam int BW = kvap_pkg::BYTE_W;

    kvap_pkg::state_t state_reg, state_next;

    logic [kvap_pkg::NUMKEYS_W-1:0] num_keys_reg;
    logic [kvap_pkg::NUMKEYS_W-1:0] emit_total_reg, emit_total_next;
    logic [kvap_pkg::KEY_W-1:0]     emit_index_reg, emit_index_next;

    logic [KC*BW-1:0] key_mem [kvap_pkg::KEY_LEN];
    logic [KC*BW-1:0] key_row_reg;

    logic [KC-1:0] found_reg, found_next;
    logic [KC-1:0] match_reg, match_next;
    logic [KC-1:0] open_reg, open_next;
    logic [kvap_pkg::TEXT_W-1:0] start_reg [KC];
    logic [kvap_pkg::TEXT_W-1:0] start_next [KC];
    logic [kvap_pkg::TEXT_W-1:0] close_reg [KC];
    logic [kvap_pkg::TEXT_W-1:0] close_next [KC];

    logic [kvap_pkg::TEXT_W-1:0] text_position_reg;
    logic [kvap_pkg::SEG_W-1:0]  segment_position_reg;
    logic                        nul_seen_reg;

    logic                           s1_valid_reg;
    logic [BW-1:0]                  s1_byte_reg;
    logic [kvap_pkg::SEG_W-1:0]     s1_seg_reg;
    logic                           s1_nul_reg;
    logic [kvap_pkg::OFFSET_W-1:0]  s1_pos_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [kvap_pkg::KEY_W-1:0]     out_key_reg;
    logic                           out_found_reg;
    logic [kvap_pkg::OFFSET_W-1:0]  out_offset_reg;
    logic [kvap_pkg::LENGTH_W-1:0]  out_length_reg;
    logic                           out_last_reg;

    logic accept;
    logic key_wr;
    logic text_acc;
    logic end_acc;
    logic clear_run;
    logic out_load;
    logic out_last;
    logic s1_amp;
    logic s1_live;
    logic item_amp;

    assign accept   = items.valid && items.ready;
    assign key_wr   = accept && (items.operation == kvap_pkg::OP_KEY_WRITE);
    assign text_acc = accept && (items.operation == kvap_pkg::OP_TEXT_BYTE)
                      && (text_position_reg < kvap_pkg::TEXT_W'(kvap_pkg::TEXT_LEN));
    assign end_acc  = accept && (items.operation == kvap_pkg::OP_END_TEXT);
    assign item_amp = !nul_seen_reg && (items.byte_value == kvap_pkg::CHAR_AMP);

    assign items.ready        = (state_reg == kvap_pkg::ST_RUN);
    assign results.valid      = out_valid_reg;
    assign results.result_key = out_key_reg;
    assign results.key_found  = out_found_reg;
    assign results.value_offset = out_offset_reg;
    assign results.value_length = out_length_reg;
    assign results.last_result  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_mem[items.char_position][items.key_index*BW +: BW] <= items.byte_value;
        end
        if (text_acc)
        begin
            key_row_reg <= key_mem[segment_position_reg[kvap_pkg::POS_W-1:0]];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        emit_total_next = emit_total_reg;
        emit_index_next = emit_index_reg;
        clear_run       = 1'b0;
        out_load        = 1'b0;
        out_last        = 1'b0;
        case (state_reg)
            kvap_pkg::ST_RUN:
            begin
                if (end_acc)
                begin
                    state_next      = kvap_pkg::ST_EMIT;
                    emit_index_next = '0;
                    emit_total_next = (num_keys_reg > kvap_pkg::NUMKEYS_W'(KC))
                                      ? kvap_pkg::NUMKEYS_W'(KC) : num_keys_reg;
                end
            end
            kvap_pkg::ST_EMIT:
            begin
                if (emit_total_reg == '0)
                begin
                    clear_run  = 1'b1;
                    state_next = kvap_pkg::ST_RUN;
                end
                else if (!out_valid_reg || results.ready)
                begin
                    out_load = 1'b1;
                    out_last = (kvap_pkg::NUMKEYS_W'(emit_index_reg)
                                + kvap_pkg::NUMKEYS_W'(1)) == emit_total_reg;
                    if (out_last)
                    begin
                        clear_run  = 1'b1;
                        state_next = kvap_pkg::ST_RUN;
                    end
                    else
                    begin
                        emit_index_next = emit_index_reg + kvap_pkg::KEY_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = kvap_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        logic [BW-1:0] key_char;
        found_next = found_reg;
        match_next = match_reg;
        open_next  = open_reg;
        start_next = start_reg;
        close_next = close_reg;
        s1_amp  = s1_valid_reg && !s1_nul_reg && (s1_byte_reg == kvap_pkg::CHAR_AMP);
        s1_live = s1_valid_reg && !s1_nul_reg && (s1_byte_reg != kvap_pkg::CHAR_NUL)
                  && (s1_byte_reg != kvap_pkg::CHAR_AMP);
        for (int k = 0; k < KC; k++)
        begin
            key_char = key_row_reg[k*BW +: BW];
            if (open_reg[k])
            begin
                if (s1_amp)
                begin
                    open_next[k]  = 1'b0;
                    close_next[k] = kvap_pkg::TEXT_W'(s1_pos_reg);
                end
            end
            else if (!found_reg[k] && s1_live && match_reg[k])
            begin
                if ((s1_seg_reg < kvap_pkg::SEG_W'(kvap_pkg::KEY_LEN))
                    && (key_char != kvap_pkg::CHAR_NUL))
                begin
                    if (kvap_pkg::fold_case(s1_byte_reg) != kvap_pkg::fold_case(key_char))
                    begin
                        match_next[k] = 1'b0;
                    end
                end
                else if ((s1_seg_reg <= kvap_pkg::SEG_W'(kvap_pkg::KEY_LEN))
                         && (s1_byte_reg == kvap_pkg::CHAR_EQUALS))
                begin
                    found_next[k] = 1'b1;
                    open_next[k]  = 1'b1;
                    start_next[k] = kvap_pkg::TEXT_W'(s1_pos_reg) + kvap_pkg::TEXT_W'(1);
                end
                else
                begin
                    match_next[k] = 1'b0;
                end
            end
        end
        if (s1_amp)
        begin
            match_next = '1;
        end
        // A key character cleared behind the current segment position shortens
        // that key below the position, so the key can no longer match here.
        if (key_wr && (items.byte_value == kvap_pkg::CHAR_NUL)
            && (kvap_pkg::SEG_W'(items.char_position) < segment_position_reg))
        begin
            match_next[items.key_index] = 1'b0;
        end
        if (clear_run)
        begin
            found_next = '0;
            match_next = '1;
            open_next  = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= kvap_pkg::ST_RUN;
            num_keys_reg         <= '0;
            emit_total_reg       <= '0;
            emit_index_reg       <= '0;
            found_reg            <= '0;
            match_reg            <= '1;
            open_reg             <= '0;
            text_position_reg    <= '0;
            segment_position_reg <= '0;
            nul_seen_reg         <= 1'b0;
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            emit_total_reg <= emit_total_next;
            emit_index_reg <= emit_index_next;
            found_reg      <= found_next;
            match_reg      <= match_next;
            open_reg       <= open_next;
            s1_valid_reg   <= text_acc;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
            begin
                num_keys_reg <= cfg_write_data;
            end
            if (clear_run)
            begin
                text_position_reg    <= '0;
                segment_position_reg <= '0;
                nul_seen_reg         <= 1'b0;
            end
            else if (text_acc)
            begin
                text_position_reg <= text_position_reg + kvap_pkg::TEXT_W'(1);
                if (item_amp)
                begin
                    segment_position_reg <= '0;
                end
                else if (segment_position_reg < kvap_pkg::SEG_W'(kvap_pkg::KEY_LEN + 1))
                begin
                    segment_position_reg <= segment_position_reg + kvap_pkg::SEG_W'(1);
                end
                if (items.byte_value == kvap_pkg::CHAR_NUL)
                begin
                    nul_seen_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        close_reg <= close_next;
        if (text_acc)
        begin
            s1_byte_reg <= items.byte_value;
            s1_seg_reg  <= segment_position_reg;
            s1_nul_reg  <= nul_seen_reg;
            s1_pos_reg  <= text_position_reg[kvap_pkg::OFFSET_W-1:0];
        end
        if (out_load)
        begin
            out_key_reg   <= emit_index_reg;
            out_found_reg <= found_reg[emit_index_reg];
            out_last_reg  <= out_last;
            if (found_reg[emit_index_reg])
            begin
                out_offset_reg <= (start_reg[emit_index_reg]
                                   > kvap_pkg::TEXT_W'(kvap_pkg::OFFSET_MAX))
                                  ? kvap_pkg::OFFSET_MAX
                                  : start_reg[emit_index_reg][kvap_pkg::OFFSET_W-1:0];
                out_length_reg <= kvap_pkg::LENGTH_W'((open_reg[emit_index_reg]
                                  ? text_position_reg : close_reg[emit_index_reg])
                                  - start_reg[emit_index_reg]);
            end
            else
            begin
                out_offset_reg <= '0;
                out_length_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/kvap_checker.sv =====
// Port-level checker for the key/value argument parser, bound to the top level.
// Depends on kvap_pkg and key_value_argument_parser_unit_macros.svh.
`default_nettype none
`include "key_value_argument_parser_unit_macros.svh"

module kvap_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            in_valid,
    input wire                            in_ready,
    input wire [kvap_pkg::OP_W-1:0]       in_operation,
    input wire                            out_valid,
    input wire                            out_ready,
    input wire [kvap_pkg::KEY_W-1:0]      out_key,
    input wire                            out_found,
    input wire [kvap_pkg::OFFSET_W-1:0]   out_offset,
    input wire [kvap_pkg::LENGTH_W-1:0]   out_length,
    input wire                            out_last
);

    logic end_accept;
    logic out_stall;

    assign end_accept = in_valid && in_ready && (in_operation == kvap_pkg::OP_END_TEXT);
    assign out_stall  = out_valid && !out_ready;

    `KVAP_ASSERT_NEXT(a_result_held, clk, rst_n, out_stall,
        out_valid && $stable(out_key) && $stable(out_found) && $stable(out_offset)
        && $stable(out_length) && $stable(out_last),
        "Stalled result transaction changed.")

    `KVAP_ASSERT_NEXT(a_end_blocks_input, clk, rst_n, end_accept, !in_ready,
        "Input accepted directly after an end of text transaction.")

    `KVAP_ASSERT_SAME(a_sweep_blocks_input, clk, rst_n, out_valid && !out_last,
        !in_ready, "Input ready while results of a run are still pending.")

    `KVAP_ASSERT_SAME(a_missing_key_zero, clk, rst_n, out_valid && !out_found,
        (out_offset == '0) && (out_length == '0),
        "Result for a key that was not found carries a nonzero offset or length.")

    `KVAP_ASSERT_SAME(a_found_offset, clk, rst_n, out_valid && out_found,
        out_offset != '0, "Found key reports a value offset of zero.")

endmodule

bind key_value_argument_parser_unit kvap_checker u_kvap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_operation (items.operation),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_key      (results.result_key),
    .out_found    (results.key_found),
    .out_offset   (results.value_offset),
    .out_length   (results.value_length),
    .out_last     (results.last_result)
);

`default_nettype wire
